// ===== src/cmcn_pkg.sv =====
// shared constants and pipeline payload types for the colour normaliser
package cmcn_pkg;

   localparam int ChanWidth   = 8;
   localparam int NumChans    = 3;
   localparam int ColourWidth = ChanWidth * NumChans;
   localparam int RemWidth    = 2 * ChanWidth;
   localparam int BitsPerStep = 2;
   localparam int NumSteps    = ChanWidth / BitsPerStep;

   localparam logic [ChanWidth-1:0] ChanFull = {ChanWidth{1'b1}};

   typedef logic [ChanWidth-1:0] chan_type;
   typedef logic [ColourWidth-1:0] colour_type;
   typedef logic [RemWidth-1:0] rem_type;

   // one item in flight through the divider: lane 2 red, lane 1 green, lane 0 blue
   typedef struct packed {
      chan_type                    top;
      rem_type [NumChans-1:0]      rem;
      chan_type [NumChans-1:0]     quo;
   } div_state_type;

endpackage

// ===== src/cmcn_max_stage.sv =====
// first pipeline stage: strongest channel search and dividend setup
module cmcn_max_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cmcn_pkg::colour_type  in_colour,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cmcn_pkg::div_state_type out_state
);
   import cmcn_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   div_state_type state_ff;
   div_state_type state_in;

   always_comb begin
      chan_type chan [NumChans];
      chan_type top;
      for (int i = 0; i < NumChans; i++) begin
         chan[i] = in_colour[i*ChanWidth +: ChanWidth];
      end
      top = chan[2];
      if (chan[1] > top) begin
         top = chan[1];
      end
      if (chan[0] > top) begin
         top = chan[0];
      end
      state_in.quo = '0;
      if (top == '0) begin
         // black: divide full scale by one so every channel comes out white
         state_in.top = chan_type'(1);
         for (int i = 0; i < NumChans; i++) begin
            state_in.rem[i] = rem_type'(ChanFull);
         end
      end else begin
         state_in.top = top;
         // c * 255 as (c << 8) - c
         for (int i = 0; i < NumChans; i++) begin
            state_in.rem[i] = {chan[i], {ChanWidth{1'b0}}} - rem_type'(chan[i]);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== src/cmcn_div_stage.sv =====
// restoring division stage: two quotient bits per lane per cycle while its output is not stalled
module cmcn_div_stage #(
   parameter int HighBit = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmcn_pkg::div_state_type in_state,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cmcn_pkg::div_state_type out_state
);
   import cmcn_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   div_state_type state_ff;
   div_state_type state_in;

   always_comb begin
      rem_type  rem_v;
      rem_type  trial;
      chan_type quo_v;
      state_in = in_state;
      for (int i = 0; i < NumChans; i++) begin
         rem_v = in_state.rem[i];
         quo_v = in_state.quo[i];
         for (int j = 0; j < BitsPerStep; j++) begin
            trial = rem_type'(in_state.top) << (HighBit - j);
            if (rem_v >= trial) begin
               rem_v = rem_v - trial;
               quo_v[HighBit - j] = 1'b1;
            end
         end
         state_in.rem[i] = rem_v;
         state_in.quo[i] = quo_v;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== src/colour_max_channel_normaliser.sv =====
// an accepted req is registered in the max stage, then in each division stage in turn
// throughput: one colour per cycle unless rsp stalls; one max stage then four
//    division stages, each settling two quotient bits of all three channels
// a stalled rsp side holds each stage, bubbles are filled as stages free up
// reset: synchronous, clears every stage valid bit; no other state
module colour_max_channel_normaliser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  cmcn_pkg::colour_type     req_tdata,   // [23:0] colour_in
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output cmcn_pkg::colour_type     rsp_tdata    // [23:0] colour_out
);
   import cmcn_pkg::*;

   logic          stage_valid [NumSteps+1];
   logic          stage_ready [NumSteps+1];
   div_state_type stage_state [NumSteps+1];

   cmcn_max_stage u_max (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_colour (req_tdata),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_state (stage_state[0])
   );

   for (genvar s = 0; s < NumSteps; s++) begin : g_div
      cmcn_div_stage #(
         .HighBit (ChanWidth - 1 - s * BitsPerStep)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_state  (stage_state[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_state (stage_state[s+1])
      );
   end

   assign stage_ready[NumSteps] = rsp_tready;
   assign rsp_tvalid = stage_valid[NumSteps];
   assign rsp_tdata  = stage_state[NumSteps].quo;

endmodule

// ===== verif/testbench.sv =====
// self-checking stream testbench for the rgb max-channel normaliser
module testbench;
   import cmcn_pkg::*;

   localparam int RandomItems   = 1550;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   colour_type req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   colour_type rsp_tdata;

   colour_type pending_colours[$];
   colour_type expected_colours[$];

   logic       running = 1'b0;
   logic       req_fired = 1'b0;
   logic [31:0] cycle_count = '0;
   int         idle_cycles = 0;
   int         fail_count = 0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   logic       calm;

   colour_max_channel_normaliser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a quarter of the time, while cycle_count[9:8] is zero, neither side idles
   assign calm = (cycle_count[9:8] == 2'b00);

   initial begin
      forever #5 clock = ~clock;
   end

   // each channel scaled by 255 / strongest channel, truncated; black becomes white
   function automatic colour_type normalised_colour(colour_type colour);
      chan_type    red, green, blue, peak;
      logic [15:0] red_scaled, green_scaled, blue_scaled;
      red   = colour[23:16];
      green = colour[15:8];
      blue  = colour[7:0];
      peak  = red;
      if (green > peak) peak = green;
      if (blue > peak) peak = blue;
      if (peak == '0) return {ColourWidth{1'b1}};
      red_scaled   = (16'(red) * 16'(ChanFull)) / 16'(peak);
      green_scaled = (16'(green) * 16'(ChanFull)) / 16'(peak);
      blue_scaled  = (16'(blue) * 16'(ChanFull)) / 16'(peak);
      return {red_scaled[7:0], green_scaled[7:0], blue_scaled[7:0]};
   endfunction

   function automatic colour_type random_colour();
      chan_type peak, red, green, blue;
      peak  = chan_type'($urandom_range(1, 255));
      red   = chan_type'($urandom_range(0, peak));
      green = chan_type'($urandom_range(0, peak));
      blue  = chan_type'($urandom_range(0, peak));
      case ($urandom_range(0, 6))
         0: return colour_type'($urandom);
         1: return {chan_type'($urandom_range(0, 15)), chan_type'($urandom_range(0, 15)),
                    chan_type'($urandom_range(0, 15))};
         // ties on the strongest channel
         2: case ($urandom_range(0, 3))
               0: return {peak, peak, blue};
               1: return {peak, green, peak};
               2: return {red, peak, peak};
               default: return {peak, peak, peak};
            endcase
         3: case ($urandom_range(0, 2))
               0: return {ChanFull, chan_type'($urandom), chan_type'($urandom)};
               1: return {chan_type'($urandom), ChanFull, chan_type'($urandom)};
               default: return {chan_type'($urandom), chan_type'($urandom), ChanFull};
            endcase
         4: case ($urandom_range(0, 2))
               0: return {peak, green, blue};
               1: return {red, peak, blue};
               default: return {red, green, peak};
            endcase
         5: case ($urandom_range(0, 2))
               0: return {peak, 8'h00, 8'h00};
               1: return {8'h00, peak, 8'h00};
               default: return {8'h00, 8'h00, peak};
            endcase
         default: return 24'h000000;
      endcase
   endfunction

   // stimulus and end of run
   initial begin
      pending_colours = '{
         24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
         24'h000001, 24'h000100, 24'h010000, 24'h010101, 24'h808000,
         24'h800080, 24'h008080, 24'h404040, 24'h7F007F, 24'h123456,
         24'hFEFF01, 24'h01FE01, 24'h010203, 24'h800000, 24'hFEFEFD,
         24'h7F8081, 24'hAAAAAB, 24'h555555
      };
      for (int i = 0; i < RandomItems; i++) begin
         pending_colours.push_back(random_colour());
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_colours.size() != 0 || expected_colours.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("colour_max_channel_normaliser test passed");
      end else begin
         $display("colour_max_channel_normaliser test failed");
      end
      $finish;
   end

   // request driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (!running) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left != 0 && !calm) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_colours.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_colours[0];
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // response back-pressure: runs of stall cycles started at random
   always @(negedge clock) begin
      if (stall_left != 0 && !calm) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 8);
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin : monitor
      colour_type wanted;
      cycle_count <= cycle_count + 1;
      running     <= !reset;
      req_fired   <= req_tvalid && req_tready;
      if (req_tvalid && req_tready) begin
         expected_colours.push_back(normalised_colour(req_tdata));
         void'(pending_colours.pop_front());
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_colours.size() == 0) begin
            $error("unexpected rsp transaction, colour_out %06h", rsp_tdata);
            fail_count++;
         end else begin
            wanted = expected_colours.pop_front();
            if (rsp_tdata !== wanted) begin
               $error("colour_out mismatch: expected %06h, actual %06h", wanted, rsp_tdata);
               fail_count++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("colour_max_channel_normaliser test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
